// ===== rtl/tbp_pkg.sv =====
package tbp_pkg;

  // blob geometry
  localparam int BLOB_BYTES = 4096;
  localparam int POS_W      = $clog2(BLOB_BYTES + 1);
  localparam int SUM_W      = ((POS_W > 16) ? POS_W : 16) + 2;

  localparam logic [POS_W-1:0] POS_END  = POS_W'(BLOB_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOB_BYTES - 1);
  localparam logic [SUM_W-1:0] SUM_END  = SUM_W'(BLOB_BYTES);

  // field limits
  localparam logic [11:0] TAG_OFF_MAX = 12'hfff;
  localparam logic [9:0]  ENTRY_MAX   = 10'h3ff;

  // header entry
  localparam logic [11:0] HDR_TAG_LEN = 12'd7;
  localparam logic [3:0]  HDR_MATCH   = 4'd7;
  localparam logic [15:0] HDR_VAL_LEN = 16'd2;
  localparam logic [7:0]  HDR_VAL0    = 8'hdd;
  localparam logic [7:0]  HDR_VAL1    = 8'hcc;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    PH_TAG    = 3'd0,
    PH_LEN_LO = 3'd1,
    PH_LEN_HI = 3'd2,
    PH_VALUE  = 3'd3,
    PH_DONE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_TAG_CHAR = 3'd0,
    KIND_TAG_END  = 3'd1,
    KIND_LENGTH   = 3'd2,
    KIND_VALUE    = 3'd3,
    KIND_END      = 3'd4,
    KIND_AFTER    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HDR_BAD = 2'd1,
    ST_FAIL    = 2'd2
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  echo;
    logic [9:0]  entry;
    logic [11:0] offset;
    logic [15:0] length;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // expected header tag characters
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h4d;
      3'd1:    c = 8'h46;
      3'd2:    c = 8'h47;
      3'd3:    c = 8'h44;
      3'd4:    c = 8'h41;
      3'd5:    c = 8'h54;
      3'd6:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/tbp_front.sv =====
module tbp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       blob_byte,
  input  logic             blob_start,
  input  tbp_pkg::qstat_t  qstat,
  output logic             push,
  output tbp_pkg::result_t push_data
);
  import tbp_pkg::*;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   blob_position, blob_position_next;
  logic [3:0]         header_match_count, header_match_count_next;
  logic [7:0]         length_low_byte, length_low_byte_next;
  logic [15:0]        value_length, value_length_next;
  logic [15:0]        value_remaining, value_remaining_next;
  logic [9:0]         current_entry, current_entry_next;
  logic [11:0]        tag_offset, tag_offset_next;
  status_t            status_code, status_code_next;

  // state seen by this byte, restart applied
  phase_t             c_phase;
  logic [POS_W-1:0]   c_pos;
  logic [3:0]         c_hmc;
  logic [7:0]         c_lenlo;
  logic [15:0]        c_vlen;
  logic [15:0]        c_vrem;
  logic [9:0]         c_entry;
  logic [11:0]        c_tagoff;
  status_t            c_status;

  logic               accept;
  logic               advance;
  logic               err;
  logic [15:0]        voff;
  logic [15:0]        vlen_new;

  assign in_stall = qstat.full;
  assign accept   = in_valid && !qstat.full;
  assign push     = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_TAG;
      blob_position      <= '0;
      header_match_count <= '0;
      length_low_byte    <= '0;
      value_length       <= '0;
      value_remaining    <= '0;
      current_entry      <= '0;
      tag_offset         <= '0;
      status_code        <= ST_OK;
    end else if (accept) begin
      phase              <= phase_next;
      blob_position      <= blob_position_next;
      header_match_count <= header_match_count_next;
      length_low_byte    <= length_low_byte_next;
      value_length       <= value_length_next;
      value_remaining    <= value_remaining_next;
      current_entry      <= current_entry_next;
      tag_offset         <= tag_offset_next;
      status_code        <= status_code_next;
    end
  end

  always_comb begin
    if (blob_start) begin
      c_phase  = PH_TAG;
      c_pos    = '0;
      c_hmc    = '0;
      c_lenlo  = '0;
      c_vlen   = '0;
      c_vrem   = '0;
      c_entry  = '0;
      c_tagoff = '0;
      c_status = ST_OK;
    end else begin
      c_phase  = phase;
      c_pos    = blob_position;
      c_hmc    = header_match_count;
      c_lenlo  = length_low_byte;
      c_vlen   = value_length;
      c_vrem   = value_remaining;
      c_entry  = current_entry;
      c_tagoff = tag_offset;
      c_status = status_code;
    end

    phase_next              = c_phase;
    blob_position_next      = c_pos;
    header_match_count_next = c_hmc;
    length_low_byte_next    = c_lenlo;
    value_length_next       = c_vlen;
    value_remaining_next    = c_vrem;
    current_entry_next      = c_entry;
    tag_offset_next         = c_tagoff;
    status_code_next        = c_status;

    advance  = 1'b0;
    err      = 1'b0;
    voff     = c_vlen - c_vrem;
    vlen_new = {blob_byte, c_lenlo};

    push_data.kind   = KIND_AFTER;
    push_data.echo   = blob_byte;
    push_data.entry  = c_entry;
    push_data.offset = '0;

    if (c_phase == PH_DONE || c_pos >= POS_END) begin
      phase_next = PH_DONE;
    end else begin
      case (c_phase)
        PH_TAG: begin
          push_data.offset = c_tagoff;
          if (blob_byte == 8'h00) begin
            if (c_tagoff == '0) begin
              push_data.kind = KIND_END;
              if (c_entry == '0) status_code_next = ST_HDR_BAD;
              phase_next = PH_DONE;
            end else begin
              push_data.kind = KIND_TAG_END;
              if (SUM_W'(c_pos) + SUM_W'(3) >= SUM_END) begin
                err = 1'b1;
              end else if (c_entry == '0 &&
                           !(c_tagoff == HDR_TAG_LEN && c_hmc == HDR_MATCH)) begin
                err = 1'b1;
              end else begin
                phase_next = PH_LEN_LO;
              end
            end
          end else begin
            push_data.kind = KIND_TAG_CHAR;
            if (c_tagoff < HDR_TAG_LEN && 12'(c_hmc) == c_tagoff &&
                blob_byte == hdr_char(c_tagoff[2:0])) begin
              header_match_count_next = c_hmc + 4'd1;
            end
            if (c_tagoff < TAG_OFF_MAX) tag_offset_next = c_tagoff + 12'd1;
            if (c_pos == POS_LAST) err = 1'b1;
          end
        end
        PH_LEN_LO: begin
          push_data.kind       = KIND_LENGTH;
          length_low_byte_next = blob_byte;
          value_length_next    = {8'h00, blob_byte};
          phase_next           = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          push_data.kind    = KIND_LENGTH;
          push_data.offset  = 12'd1;
          value_length_next = vlen_new;
          if (SUM_W'(c_pos) + SUM_W'(1) + SUM_W'(vlen_new) >= SUM_END) begin
            err = 1'b1;
          end else if (c_entry == '0 && vlen_new != HDR_VAL_LEN) begin
            err = 1'b1;
          end else if (vlen_new == '0) begin
            advance = 1'b1;
          end else begin
            value_remaining_next = vlen_new;
            phase_next           = PH_VALUE;
          end
        end
        PH_VALUE: begin
          push_data.kind   = KIND_VALUE;
          push_data.offset = voff[11:0];
          if (c_entry == '0 &&
              ((voff == 16'd0 && blob_byte != HDR_VAL0) ||
               (voff == 16'd1 && blob_byte != HDR_VAL1))) begin
            err = 1'b1;
          end else begin
            value_remaining_next = c_vrem - 16'd1;
            if (c_vrem == 16'd1) advance = 1'b1;
          end
        end
        default: begin
          phase_next = PH_DONE;
        end
      endcase
    end

    if (err) begin
      status_code_next = (c_entry == '0) ? ST_HDR_BAD : ST_FAIL;
      phase_next       = PH_DONE;
    end

    push_data.length = (push_data.kind == KIND_TAG_CHAR ||
                        push_data.kind == KIND_TAG_END) ? 16'd0 : value_length_next;
    push_data.status = status_code_next;

    if (advance) begin
      if (c_entry < ENTRY_MAX) current_entry_next = c_entry + 10'd1;
      tag_offset_next         = '0;
      header_match_count_next = '0;
      value_length_next       = '0;
      value_remaining_next    = '0;
      phase_next              = PH_TAG;
    end

    if (c_pos < POS_END) blob_position_next = c_pos + POS_W'(1);
  end

endmodule

// ===== rtl/tbp_queue.sv =====
module tbp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tbp_pkg::result_t push_data,
  input  logic             pop,
  output tbp_pkg::result_t head,
  output tbp_pkg::qstat_t  qstat
);
  import tbp_pkg::*;

  result_t            mem [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign qstat.full  = (count == QCNT_W'(QDEPTH));
  assign qstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tbp_back.sv =====
module tbp_back (
  input  logic             clk,
  input  logic             rst,
  input  tbp_pkg::qstat_t  qstat,
  input  tbp_pkg::result_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output tbp_pkg::result_t out_data
);
  import tbp_pkg::*;

  // load the output register when it is empty or being taken
  assign pop = !qstat.empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= !qstat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data <= head;
  end

endmodule

// ===== rtl/tlv_blob_parser.sv =====
// tlv_blob_parser: streaming tag/length/value parser for a fixed-size blob
//
// input channel: one blob byte per transaction (blob_byte), blob_start marks
//   the first byte of a new blob and restarts the parse at that byte
// output channel: one result transaction per input byte with the byte kind,
//   the echoed byte, entry number, offset in the tag or value, decoded value
//   length and parse status
// path: an accepted byte's result is written into the queue, then loaded into the output register
// throughput: one byte per cycle while the queue is not full; the front parser
//   computes its next phase state combinationally, so the rate is set by the queue and output register
// a four-deep queue sits between the parser and the output register, so the
//   input keeps flowing while the receiver stalls until the queue fills;
//   in_stall is high only while the queue is full
// under out_stall the output register holds its transaction unchanged
// reset empties the queue, drops out_valid and puts the parser at blob
//   position zero in the tag phase, as if blob_start had been seen
module tlv_blob_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  blob_byte,
  input  logic        blob_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  byte_kind,
  output logic [7:0]  echo_byte,
  output logic [9:0]  entry_number,
  output logic [11:0] field_offset,
  output logic [15:0] entry_length,
  output logic [1:0]  parse_status
);
  import tbp_pkg::*;

  // front to queue
  logic    push;
  result_t push_data;

  // queue to back
  logic    pop;
  result_t head;
  qstat_t  qstat;

  result_t out_data;

  // parser: classifies each byte and updates the phase state
  tbp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .blob_byte  (blob_byte),
    .blob_start (blob_start),
    .qstat      (qstat),
    .push       (push),
    .push_data  (push_data)
  );

  // decouples the parser from output backpressure
  tbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // output register on the result channel
  tbp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign byte_kind    = out_data.kind;
  assign echo_byte    = out_data.echo;
  assign entry_number = out_data.entry;
  assign field_offset = out_data.offset;
  assign entry_length = out_data.length;
  assign parse_status = out_data.status;

`ifndef SYNTHESIS
  // the header entry never reports a plain parse failure
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(entry_number == '0 && parse_status == ST_FAIL))
    else $error("parse failure reported inside header entry");

  // tag bytes carry no decoded length
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_kind == KIND_TAG_CHAR || byte_kind == KIND_TAG_END)
      |-> entry_length == '0)
    else $error("nonzero length on a tag byte");

  // length bytes sit at offset zero or one
  assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_LENGTH |-> field_offset <= 12'd1)
    else $error("length byte offset out of range");

  // a full queue must push back on the input
  assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> in_stall && !push)
    else $error("push into a full queue");
`endif

endmodule

// ===== tb/tb_tlv_blob_parser.sv =====
module tb_tlv_blob_parser;
  import tbp_pkg::*;

  // header tag text, byte i is character i
  localparam logic [0:6][7:0] HDR_NAME = {8'h4d, 8'h46, 8'h47, 8'h44, 8'h41, 8'h54, 8'h41};

  // one input transaction as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } blob_xfer_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  blob_byte = 8'h00;
  logic        blob_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  byte_kind;
  logic [7:0]  echo_byte;
  logic [9:0]  entry_number;
  logic [11:0] field_offset;
  logic [15:0] entry_length;
  logic [1:0]  parse_status;

  blob_xfer_t pending_bytes[$];     // bytes still to be offered
  result_t    predicted_reports[$]; // per-byte reports not yet seen
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         hold_left = 0;
  logic       quiet;

  // parser state as the testbench tracks it
  phase_t             ph_now;
  logic [POS_W-1:0]   blob_pos;
  logic [3:0]         hdr_hits;
  logic [7:0]         len_low;
  logic [15:0]        val_len;
  logic [15:0]        val_left;
  logic [9:0]         entry_idx;
  logic [11:0]        tag_pos;
  status_t            status_now;

  tlv_blob_parser u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .blob_byte    (blob_byte),
    .blob_start   (blob_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .byte_kind    (byte_kind),
    .echo_byte    (echo_byte),
    .entry_number (entry_number),
    .field_offset (field_offset),
    .entry_length (entry_length),
    .parse_status (parse_status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // stretch where neither side idles
  assign quiet = (cycle_count >= 900) && (cycle_count < 1300);

  // ---------------------------------------------------------------------------
  // parser prediction
  // ---------------------------------------------------------------------------

  // back to blob position zero, tag phase, status ok
  task automatic clear_parser();
    ph_now     = PH_TAG;
    blob_pos   = '0;
    hdr_hits   = '0;
    len_low    = '0;
    val_len    = '0;
    val_left   = '0;
    entry_idx  = '0;
    tag_pos    = '0;
    status_now = ST_OK;
  endtask

  // any error stops the parse; inside the header entry it counts as header bad
  task automatic abort_parse();
    if (entry_idx == '0) begin
      status_now = ST_HDR_BAD;
    end else begin
      status_now = ST_FAIL;
    end
    ph_now = PH_DONE;
  endtask

  task automatic open_next_entry();
    if (entry_idx != ENTRY_MAX) begin
      entry_idx = entry_idx + 1'b1;
    end
    tag_pos  = '0;
    hdr_hits = '0;
    val_len  = '0;
    val_left = '0;
    ph_now   = PH_TAG;
  endtask

  // classify one blob byte and advance the tracked parser state
  task automatic parse_byte(input logic [7:0] b, input logic restart, output result_t rep);
    int   p;
    int   voff;
    logic advance;
    if (restart) begin
      clear_parser();
    end
    p          = int'(blob_pos);
    advance    = 1'b0;
    rep.kind   = KIND_AFTER;
    rep.echo   = b;
    rep.entry  = entry_idx;
    rep.offset = '0;
    if (ph_now == PH_DONE || p >= BLOB_BYTES) begin
      // finished, or past the end of the blob
      ph_now = PH_DONE;
    end else if (ph_now == PH_TAG) begin
      rep.offset = tag_pos;
      if (b == 8'h00) begin
        if (tag_pos == '0) begin
          // empty tag ends the data; an empty header tag is a bad header
          rep.kind = KIND_END;
          if (entry_idx == '0) begin
            status_now = ST_HDR_BAD;
          end
          ph_now = PH_DONE;
        end else begin
          rep.kind = KIND_TAG_END;
          if (p + 3 >= BLOB_BYTES) begin
            // no room left for both length bytes and a byte after them
            abort_parse();
          end else if (entry_idx == '0 && !(tag_pos == 12'd7 && hdr_hits == 4'd7)) begin
            abort_parse();
          end else begin
            ph_now = PH_LEN_LO;
          end
        end
      end else begin
        rep.kind = KIND_TAG_CHAR;
        if (tag_pos < 12'd7 && hdr_hits == tag_pos && b == HDR_NAME[tag_pos[2:0]]) begin
          hdr_hits = hdr_hits + 1'b1;
        end
        if (tag_pos != TAG_OFF_MAX) begin
          tag_pos = tag_pos + 1'b1;
        end
        // tag still open at the last byte of the blob
        if (p == BLOB_BYTES - 1) begin
          abort_parse();
        end
      end
    end else if (ph_now == PH_LEN_LO) begin
      rep.kind = KIND_LENGTH;
      len_low  = b;
      val_len  = {8'h00, b};
      ph_now   = PH_LEN_HI;
    end else if (ph_now == PH_LEN_HI) begin
      rep.kind   = KIND_LENGTH;
      rep.offset = 12'd1;
      val_len    = {b, len_low};
      if (p + 1 + int'(val_len) >= BLOB_BYTES) begin
        // value would reach the last byte of the blob or run past it
        abort_parse();
      end else if (entry_idx == '0 && val_len != HDR_VAL_LEN) begin
        abort_parse();
      end else if (val_len == '0) begin
        advance = 1'b1;
      end else begin
        val_left = val_len;
        ph_now   = PH_VALUE;
      end
    end else begin
      voff       = int'(val_len) - int'(val_left);
      rep.kind   = KIND_VALUE;
      rep.offset = voff[11:0];
      if (entry_idx == '0 && ((voff == 0 && b != HDR_VAL0) || (voff == 1 && b != HDR_VAL1))) begin
        abort_parse();
      end else begin
        val_left = val_left - 1'b1;
        if (val_left == '0) begin
          advance = 1'b1;
        end
      end
    end
    // length reads as zero while a tag is in progress
    if (rep.kind == KIND_TAG_CHAR || rep.kind == KIND_TAG_END) begin
      rep.length = '0;
    end else begin
      rep.length = val_len;
    end
    rep.status = status_now;
    if (advance) begin
      open_next_entry();
    end
    if (p < BLOB_BYTES) begin
      blob_pos = blob_pos + 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic add_byte(input logic [7:0] b, input logic restart);
    pending_bytes.push_back(blob_xfer_t'{data: b, first: restart});
  endtask

  // well-formed header entry, opening a new blob
  task automatic add_header();
    for (int i = 0; i < 7; i++) begin
      add_byte(HDR_NAME[i], i == 0);
    end
    add_byte(8'h00, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(HDR_VAL0, 1'b0);
    add_byte(HDR_VAL1, 1'b0);
  endtask

  // random nonzero tag, terminator, little-endian length, random value bytes
  task automatic add_tlv_record(input int tag_chars, input int vlen);
    for (int i = 0; i < tag_chars; i++) begin
      add_byte(8'($urandom_range(255, 1)), 1'b0);
    end
    add_byte(8'h00, 1'b0);
    add_byte(vlen[7:0], 1'b0);
    add_byte(vlen[15:8], 1'b0);
    for (int i = 0; i < vlen; i++) begin
      add_byte(8'($urandom), 1'b0);
    end
  endtask

  // mostly well-formed short blobs, some with one flipped bit, some pure noise
  task automatic add_short_blob();
    int shape;
    int first_idx;
    int flip_idx;
    int n;
    shape     = $urandom_range(99);
    first_idx = pending_bytes.size();
    if (shape < 12) begin
      // noise, with an occasional restart in the middle
      n = $urandom_range(20, 1);
      for (int i = 0; i < n; i++) begin
        add_byte(8'($urandom), (i == 0) || ($urandom_range(49) == 0));
      end
    end else begin
      add_header();
      n = $urandom_range(4);
      repeat (n) begin
        add_tlv_record($urandom_range(6, 1),
                       ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(12));
      end
      // sometimes no end marker: the next blob_start cuts the blob short
      if ($urandom_range(9) != 0) begin
        add_byte(8'h00, 1'b0);
      end
      repeat ($urandom_range(3)) begin
        add_byte(8'($urandom), 1'b0);
      end
      if (shape < 40) begin
        // broken blob: one bit flipped somewhere
        flip_idx = $urandom_range(pending_bytes.size() - 1, first_idx);
        pending_bytes[flip_idx].data = pending_bytes[flip_idx].data ^
                                       (8'h01 << $urandom_range(7));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued bytes, idles at random outside the quiet stretch
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    blob_xfer_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      // no transaction pending, or the current one is taken at this edge
      if (pending_bytes.size() != 0 && (quiet || $urandom_range(99) >= 27)) begin
        nxt = pending_bytes.pop_front();
        in_valid   <= 1'b1;
        blob_byte  <= nxt.data;
        blob_start <= nxt.first;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall, plus one long hold-off to fill the internal queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (cycle_count == 400) begin
      hold_left <= 180;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 27);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on each accepted input transaction, checks each output
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d (0x%0h), got %0d (0x%0h)", name, want, want, got, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    result_t want;
    if (!rst) begin
      // prediction first, so a report is queued before it can be checked
      if (in_valid && !in_stall) begin
        parse_byte(blob_byte, blob_start, want);
        predicted_reports.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (predicted_reports.size() == 0) begin
          $error("output transaction with nothing predicted: kind %0d byte 0x%0h",
                 byte_kind, echo_byte);
          mismatch_count++;
        end else begin
          want = predicted_reports.pop_front();
          check_field("byte_kind", int'(want.kind), int'(byte_kind));
          check_field("echo_byte", int'(want.echo), int'(echo_byte));
          check_field("entry_number", int'(want.entry), int'(entry_number));
          check_field("field_offset", int'(want.offset), int'(field_offset));
          check_field("entry_length", int'(want.length), int'(entry_length));
          check_field("parse_status", int'(want.status), int'(parse_status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    clear_parser();

    // no blob_start after reset: empty first tag is a bad header, then finished
    add_byte(8'h00, 1'b0);
    add_byte(8'hff, 1'b0);
    // header tag wrong in its last character, caught at the tag end
    for (int i = 0; i < 7; i++) begin
      add_byte((i == 6) ? 8'h42 : HDR_NAME[i], i == 0);
    end
    add_byte(8'h00, 1'b0);
    // good header, then an entry whose value would end exactly at the blob end
    add_header();
    add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'hf0, 1'b0);
    add_byte(8'h0f, 1'b0);

    // random short blobs
    while (pending_bytes.size() < 1350) begin
      add_short_blob();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // every byte offered and taken
    while (pending_bytes.size() != 0 || in_valid) begin
      @(posedge clk);
    end
    for (int k = 0; k < 4000 && predicted_reports.size() != 0; k++) begin
      @(posedge clk);
    end
    if (predicted_reports.size() != 0) begin
      $error("%0d predicted reports never came out", predicted_reports.size());
      mismatch_count++;
    end
    // room for any stray extra output transaction
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard limit on run time
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== tlv_blob_parser.f =====
rtl/tbp_pkg.sv
rtl/tbp_front.sv
rtl/tbp_queue.sv
rtl/tbp_back.sv
rtl/tlv_blob_parser.sv
tb/tb_tlv_blob_parser.sv
